// ----- design/des_fr_pkg.sv -----
package des_fr_pkg;

  localparam int BLOCK_W = 64;
  localparam int HALF_W  = 32;
  localparam int KEY_W   = 48;
  localparam int IDX_W   = 4;
  localparam int NUM_SBOX = 8;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_ROUND = 1'b1
  } cmd_t;

  // Last round of the cipher: no half swap after it.
  localparam logic [IDX_W-1:0] LAST_ROUND = 4'd15;

  // Table entries count bits from 1 at the MSB, as in the DES standard.
  localparam int unsigned IP_TBL [64] = '{
    58, 50, 42, 34, 26, 18, 10, 2, 60, 52, 44, 36, 28, 20, 12, 4,
    62, 54, 46, 38, 30, 22, 14, 6, 64, 56, 48, 40, 32, 24, 16, 8,
    57, 49, 41, 33, 25, 17, 9, 1, 59, 51, 43, 35, 27, 19, 11, 3,
    61, 53, 45, 37, 29, 21, 13, 5, 63, 55, 47, 39, 31, 23, 15, 7
  };

  localparam int unsigned E_TBL [48] = '{
    32, 1, 2, 3, 4, 5, 4, 5, 6, 7, 8, 9,
    8, 9, 10, 11, 12, 13, 12, 13, 14, 15, 16, 17,
    16, 17, 18, 19, 20, 21, 20, 21, 22, 23, 24, 25,
    24, 25, 26, 27, 28, 29, 28, 29, 30, 31, 32, 1
  };

  localparam int unsigned P_TBL [32] = '{
    16, 7, 20, 21, 29, 12, 28, 17, 1, 15, 23, 26, 5, 18, 31, 10,
    2, 8, 24, 14, 32, 27, 3, 9, 19, 13, 30, 6, 22, 11, 4, 25
  };

  // Index is {row, col}: row from the outer bits, col from the inner four.
  localparam logic [3:0] SBOX_TBL [NUM_SBOX][64] = '{
    '{14, 4, 13, 1, 2, 15, 11, 8, 3, 10, 6, 12, 5, 9, 0, 7,
      0, 15, 7, 4, 14, 2, 13, 1, 10, 6, 12, 11, 9, 5, 3, 8,
      4, 1, 14, 8, 13, 6, 2, 11, 15, 12, 9, 7, 3, 10, 5, 0,
      15, 12, 8, 2, 4, 9, 1, 7, 5, 11, 3, 14, 10, 0, 6, 13},
    '{15, 1, 8, 14, 6, 11, 3, 4, 9, 7, 2, 13, 12, 0, 5, 10,
      3, 13, 4, 7, 15, 2, 8, 14, 12, 0, 1, 10, 6, 9, 11, 5,
      0, 14, 7, 11, 10, 4, 13, 1, 5, 8, 12, 6, 9, 3, 2, 15,
      13, 8, 10, 1, 3, 15, 4, 2, 11, 6, 7, 12, 0, 5, 14, 9},
    '{10, 0, 9, 14, 6, 3, 15, 5, 1, 13, 12, 7, 11, 4, 2, 8,
      13, 7, 0, 9, 3, 4, 6, 10, 2, 8, 5, 14, 12, 11, 15, 1,
      13, 6, 4, 9, 8, 15, 3, 0, 11, 1, 2, 12, 5, 10, 14, 7,
      1, 10, 13, 0, 6, 9, 8, 7, 4, 15, 14, 3, 11, 5, 2, 12},
    '{7, 13, 14, 3, 0, 6, 9, 10, 1, 2, 8, 5, 11, 12, 4, 15,
      13, 8, 11, 5, 6, 15, 0, 3, 4, 7, 2, 12, 1, 10, 14, 9,
      10, 6, 9, 0, 12, 11, 7, 13, 15, 1, 3, 14, 5, 2, 8, 4,
      3, 15, 0, 6, 10, 1, 13, 8, 9, 4, 5, 11, 12, 7, 2, 14},
    '{2, 12, 4, 1, 7, 10, 11, 6, 8, 5, 3, 15, 13, 0, 14, 9,
      14, 11, 2, 12, 4, 7, 13, 1, 5, 0, 15, 10, 3, 9, 8, 6,
      4, 2, 1, 11, 10, 13, 7, 8, 15, 9, 12, 5, 6, 3, 0, 14,
      11, 8, 12, 7, 1, 14, 2, 13, 6, 15, 0, 9, 10, 4, 5, 3},
    '{12, 1, 10, 15, 9, 2, 6, 8, 0, 13, 3, 4, 14, 7, 5, 11,
      10, 15, 4, 2, 7, 12, 9, 5, 6, 1, 13, 14, 0, 11, 3, 8,
      9, 14, 15, 5, 2, 8, 12, 3, 7, 0, 4, 10, 1, 13, 11, 6,
      4, 3, 2, 12, 9, 5, 15, 10, 11, 14, 1, 7, 6, 0, 8, 13},
    '{4, 11, 2, 14, 15, 0, 8, 13, 3, 12, 9, 7, 5, 10, 6, 1,
      13, 0, 11, 7, 4, 9, 1, 10, 14, 3, 5, 12, 2, 15, 8, 6,
      1, 4, 11, 13, 12, 3, 7, 14, 10, 15, 6, 8, 0, 5, 9, 2,
      6, 11, 13, 8, 1, 4, 10, 7, 9, 5, 0, 15, 14, 2, 3, 12},
    '{13, 2, 8, 4, 6, 15, 11, 1, 10, 9, 3, 14, 5, 0, 12, 7,
      1, 15, 13, 8, 10, 3, 7, 4, 12, 5, 6, 11, 0, 14, 9, 2,
      7, 11, 4, 1, 9, 12, 14, 2, 0, 6, 10, 13, 15, 3, 5, 8,
      2, 1, 14, 7, 4, 10, 8, 13, 15, 12, 9, 0, 3, 5, 6, 11}
  };

endpackage

// ----- design/des_fr_if.sv -----
interface des_fr_in_if
  import des_fr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              command;
  logic [BLOCK_W-1:0] block_in;
  logic [KEY_W-1:0]   round_key;
  logic [IDX_W-1:0]   round_index;

  modport source (output valid, command, block_in, round_key, round_index, input ready);
  modport sink   (input valid, command, block_in, round_key, round_index, output ready);
endinterface

interface des_fr_out_if
  import des_fr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [HALF_W-1:0] left_out;
  logic [HALF_W-1:0] right_out;

  modport source (output valid, left_out, right_out, input ready);
  modport sink   (input valid, left_out, right_out, output ready);
endinterface

// ----- design/des_feistel_round.sv -----
// Channel | Dir | Payload                                       | Handshake
// in_ch   | in  | command, block_in, round_key, round_index     | valid/ready
// out_ch  | out | left_out, right_out                           | valid/ready
//
// Each transaction passes an input register, then the combinational IP or
// round logic, and lands in the half registers that drive out_ch, which
// hold the result until it is taken; one transaction per cycle is sustained
// while out_ch stays ready.
// Reset (rst_n low, synchronous) clears both halves and all valid flags.
// A stall on out_ch holds the result and the waiting input; in_ch stays
// ready while the input register is empty or about to move on.
module des_feistel_round
  import des_fr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  des_fr_in_if.sink        in_ch,
  des_fr_out_if.source     out_ch
);

  // Input register stage.
  logic               s1_valid_r;
  cmd_t               s1_cmd_r;
  logic [BLOCK_W-1:0] s1_block_r;
  logic [KEY_W-1:0]   s1_key_r;
  logic [IDX_W-1:0]   s1_idx_r;

  // Cipher state; these also serve as the result register.
  logic [HALF_W-1:0]  left_r, left_nxt;
  logic [HALF_W-1:0]  right_r, right_nxt;
  logic               out_valid_r;

  logic               in_fire;
  logic               s1_advance;
  logic [BLOCK_W-1:0] ip_block;
  logic [HALF_W-1:0]  f_val;
  logic [HALF_W-1:0]  mixed;

  // Advance the input stage whenever the result slot is free or draining.
  assign s1_advance = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_advance;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  // Payload: capture on acceptance, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r   <= cmd_t'(in_ch.command);
      s1_block_r <= in_ch.block_in;
      s1_key_r   <= in_ch.round_key;
      s1_idx_r   <= in_ch.round_index;
    end
  end

  des_fr_ip u_ip (
    .block    (s1_block_r),
    .permuted (ip_block)
  );

  des_fr_feistel u_feistel (
    .right_half (right_r),
    .round_key  (s1_key_r),
    .f_out      (f_val)
  );

  assign mixed = left_r ^ f_val;

  // Next halves: load splits the permuted block; a round swaps unless last.
  always_comb begin
    left_nxt  = left_r;
    right_nxt = right_r;
    unique case (s1_cmd_r)
      CMD_LOAD: begin
        left_nxt  = ip_block[BLOCK_W-1:HALF_W];
        right_nxt = ip_block[HALF_W-1:0];
      end
      CMD_ROUND: begin
        if (s1_idx_r == LAST_ROUND) begin
          left_nxt = mixed;
        end else begin
          left_nxt  = right_r;
          right_nxt = mixed;
        end
      end
      default: begin
        left_nxt  = left_r;
        right_nxt = right_r;
      end
    endcase
  end

  // Halves change only when a transaction moves into the result slot,
  // so a stalled result holds steady.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r  <= '0;
      right_r <= '0;
    end else if (s1_advance) begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.left_out  = left_r;
  assign out_ch.right_out = right_r;

endmodule

// ----- design/des_fr_ip.sv -----
module des_fr_ip
  import des_fr_pkg::*;
(
  input  logic [BLOCK_W-1:0] block,
  output logic [BLOCK_W-1:0] permuted
);

  // Pure wiring: output bit i (from MSB) takes table bit IP_TBL[i].
  for (genvar i = 0; i < BLOCK_W; i++) begin : g_ip
    assign permuted[BLOCK_W-1-i] = block[BLOCK_W - IP_TBL[i]];
  end

endmodule

// ----- design/des_fr_feistel.sv -----
module des_fr_feistel
  import des_fr_pkg::*;
(
  input  logic [HALF_W-1:0] right_half,
  input  logic [KEY_W-1:0]  round_key,
  output logic [HALF_W-1:0] f_out
);

  logic [KEY_W-1:0]  expanded;
  logic [KEY_W-1:0]  mixed;
  logic [HALF_W-1:0] sbox_out;

  // Expansion: 32 -> 48 bits.
  for (genvar i = 0; i < KEY_W; i++) begin : g_exp
    assign expanded[KEY_W-1-i] = right_half[HALF_W - E_TBL[i]];
  end

  assign mixed = expanded ^ round_key;

  // Eight S-boxes, six bits in and four out each.
  for (genvar b = 0; b < NUM_SBOX; b++) begin : g_sbox
    logic [5:0] six;
    assign six = mixed[KEY_W-1-6*b -: 6];
    assign sbox_out[HALF_W-1-4*b -: 4] = SBOX_TBL[b][{six[5], six[0], six[4:1]}];
  end

  // P permutation.
  for (genvar i = 0; i < HALF_W; i++) begin : g_perm
    assign f_out[HALF_W-1-i] = sbox_out[HALF_W - P_TBL[i]];
  end

endmodule
